@@ rtl/lavm_pkg.sv @@
// lavm_pkg: shared types, constants and the integer square root step
// used by the look-at view matrix pipeline; no dependencies
package lavm_pkg;

  localparam int COORD_W    = 32;
  localparam int ROT_W      = 18;
  localparam int NORM_BITS  = 30;
  localparam int SQ_W       = 64;
  localparam int SQRT_STEPS = 32;

  typedef struct packed {
    logic [SQ_W-1:0] s;
    logic [SQ_W-1:0] res;
  } sqrt_st_t;

  // one digit of the bitwise integer square root, test bit 2^pos
  function automatic sqrt_st_t sqrt_step(sqrt_st_t st, int unsigned pos);
    sqrt_st_t        o;
    logic [SQ_W-1:0] b;
    logic [SQ_W-1:0] t;
    b = SQ_W'(1) << pos;
    t = st.res + b;
    if (st.s >= t) begin
      o.s   = st.s - t;
      o.res = (st.res >> 1) + b;
    end else begin
      o.s   = st.s;
      o.res = st.res >> 1;
    end
    return o;
  endfunction

endpackage

@@ rtl/lavm_norm.sv @@
// lavm_norm: pipelined fixed-point normalization of a 3-vector with a
// sideband that travels alongside; depends on lavm_pkg
module lavm_norm #(
  parameter int W  = 33,
  parameter int FB = 16,
  parameter int SW = 8
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 en,
  input  logic                 in_vld,
  input  logic [3*W-1:0]       in_vec,
  input  logic [SW-1:0]        in_side,
  output logic                 out_vld,
  output logic [3*(FB+2)-1:0]  out_vec,
  output logic [SW-1:0]        out_side
);

  localparam int NB  = lavm_pkg::NORM_BITS;
  localparam int LW  = $clog2(W + 1);
  localparam int OW  = FB + 2;
  localparam int QW  = FB + 1;
  localparam int MW  = NB + 1;
  localparam int NW  = NB + FB + 1;
  localparam int SQN = lavm_pkg::SQRT_STEPS / 2;
  localparam int DW  = SW + 4;
  localparam int CW  = DW + 3 * NB;

  // stage a: magnitude and sign
  logic          a_vld_r;
  logic [W-1:0]  a_abs_r [3];
  logic [2:0]    a_sgn_r;
  logic [SW-1:0] a_side_r;
  logic [W-1:0]  abs_nxt [3];
  logic [2:0]    sgn_nxt;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      sgn_nxt[i] = in_vec[i*W + W-1];
      abs_nxt[i] = sgn_nxt[i] ? (~in_vec[i*W +: W] + W'(1)) : in_vec[i*W +: W];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_vld_r <= 1'b0;
    end else if (en) begin
      a_vld_r <= in_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      a_abs_r  <= abs_nxt;
      a_sgn_r  <= sgn_nxt;
      a_side_r <= in_side;
    end
  end

  // stage b: bit length of the largest magnitude
  logic          b_vld_r;
  logic [W-1:0]  b_abs_r [3];
  logic [2:0]    b_sgn_r;
  logic          b_zero_r;
  logic [LW-1:0] b_len_r;
  logic [SW-1:0] b_side_r;
  logic [W-1:0]  orv;
  logic [LW-1:0] len_nxt;

  always_comb begin
    orv     = a_abs_r[0] | a_abs_r[1] | a_abs_r[2];
    len_nxt = '0;
    for (int b = 0; b < W; b++) begin
      if (orv[b]) begin
        len_nxt = LW'(b + 1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      b_vld_r <= 1'b0;
    end else if (en) begin
      b_vld_r <= a_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      b_abs_r  <= a_abs_r;
      b_sgn_r  <= a_sgn_r;
      b_zero_r <= (orv == '0);
      b_len_r  <= len_nxt;
      b_side_r <= a_side_r;
    end
  end

  // stage c: scale so the largest magnitude has NB bits
  logic            c_vld_r;
  logic [CW-1:0]   c_cw_r;
  logic [W+NB-1:0] ext [3];
  logic [CW-1:0]   c_cw_nxt;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      ext[i] = {b_abs_r[i], {NB{1'b0}}} >> b_len_r;
    end
    c_cw_nxt = {b_side_r, b_sgn_r, b_zero_r,
                ext[2][NB-1:0], ext[1][NB-1:0], ext[0][NB-1:0]};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      c_vld_r <= 1'b0;
    end else if (en) begin
      c_vld_r <= b_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      c_cw_r <= c_cw_nxt;
    end
  end

  // stage d: squares
  logic            d_vld_r;
  logic [CW-1:0]   d_cw_r;
  logic [2*NB-1:0] d_sq_r [3];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      d_vld_r <= 1'b0;
    end else if (en) begin
      d_vld_r <= c_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      d_cw_r <= c_cw_r;
      for (int i = 0; i < 3; i++) begin
        d_sq_r[i] <= c_cw_r[i*NB +: NB] * c_cw_r[i*NB +: NB];
      end
    end
  end

  // stage e and square root digits
  logic                        sq_v_r [SQN+1];
  logic [lavm_pkg::SQ_W-1:0]   sq_s_r [SQN+1];
  logic [lavm_pkg::SQ_W-1:0]   sq_q_r [SQN+1];
  logic [CW-1:0]               sq_c_r [SQN+1];
  logic [2*NB+1:0]             sum_nxt;

  assign sum_nxt = (2*NB+2)'(d_sq_r[0]) + (2*NB+2)'(d_sq_r[1]) + (2*NB+2)'(d_sq_r[2]);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sq_v_r[0] <= 1'b0;
    end else if (en) begin
      sq_v_r[0] <= d_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      sq_s_r[0] <= lavm_pkg::SQ_W'(sum_nxt);
      sq_q_r[0] <= '0;
      sq_c_r[0] <= d_cw_r;
    end
  end

  for (genvar k = 0; k < SQN; k++) begin : g_sqrt
    lavm_pkg::sqrt_st_t st0, st1, st2;

    always_comb begin
      st0.s   = sq_s_r[k];
      st0.res = sq_q_r[k];
      st1     = lavm_pkg::sqrt_step(st0, 62 - 4*k);
      st2     = lavm_pkg::sqrt_step(st1, 60 - 4*k);
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        sq_v_r[k+1] <= 1'b0;
      end else if (en) begin
        sq_v_r[k+1] <= sq_v_r[k];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        sq_s_r[k+1] <= st2.s;
        sq_q_r[k+1] <= st2.res;
        sq_c_r[k+1] <= sq_c_r[k];
      end
    end
  end

  // division: rounded component over magnitude, one quotient bit a stage
  logic          dv_v_r   [QW+1];
  logic [NW-1:0] dv_rem_r [QW+1][3];
  logic [QW-1:0] dv_q_r   [QW+1][3];
  logic [MW-1:0] dv_mag_r [QW+1];
  logic [DW-1:0] dv_c_r   [QW+1];
  logic [MW-1:0] mag;

  assign mag = sq_q_r[SQN][MW-1:0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dv_v_r[0] <= 1'b0;
    end else if (en) begin
      dv_v_r[0] <= sq_v_r[SQN];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      dv_mag_r[0] <= mag;
      dv_c_r[0]   <= sq_c_r[SQN][CW-1 -: DW];
      for (int i = 0; i < 3; i++) begin
        dv_rem_r[0][i] <= NW'({sq_c_r[SQN][i*NB +: NB], {FB{1'b0}}}) + NW'(mag >> 1);
        dv_q_r[0][i]   <= '0;
      end
    end
  end

  for (genvar k = 0; k < QW; k++) begin : g_div
    logic [NW-1:0] dsh;
    logic [NW-1:0] rem_n [3];
    logic [QW-1:0] q_n   [3];

    always_comb begin
      dsh = NW'(dv_mag_r[k]) << (QW - 1 - k);
      for (int i = 0; i < 3; i++) begin
        if (dv_rem_r[k][i] >= dsh) begin
          rem_n[i] = dv_rem_r[k][i] - dsh;
          q_n[i]   = dv_q_r[k][i] | (QW'(1) << (QW - 1 - k));
        end else begin
          rem_n[i] = dv_rem_r[k][i];
          q_n[i]   = dv_q_r[k][i];
        end
      end
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        dv_v_r[k+1] <= 1'b0;
      end else if (en) begin
        dv_v_r[k+1] <= dv_v_r[k];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        dv_rem_r[k+1] <= rem_n;
        dv_q_r[k+1]   <= q_n;
        dv_mag_r[k+1] <= dv_mag_r[k];
        dv_c_r[k+1]   <= dv_c_r[k];
      end
    end
  end

  // final: clamp to one, apply sign, zero vector stays zero
  logic             o_vld_r;
  logic [3*OW-1:0]  o_vec_r;
  logic [SW-1:0]    o_side_r;
  logic [3*OW-1:0]  vec_nxt;
  logic [QW-1:0]    qc;
  logic             fz;
  logic [2:0]       fsgn;

  always_comb begin
    fz      = dv_c_r[QW][0];
    fsgn    = dv_c_r[QW][3:1];
    vec_nxt = '0;
    for (int i = 0; i < 3; i++) begin
      qc = (dv_q_r[QW][i] > (QW'(1) << FB)) ? (QW'(1) << FB) : dv_q_r[QW][i];
      if (!fz) begin
        vec_nxt[i*OW +: OW] = fsgn[i] ? (OW'(0) - OW'(qc)) : OW'(qc);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      o_vld_r <= 1'b0;
    end else if (en) begin
      o_vld_r <= dv_v_r[QW];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      o_vec_r  <= vec_nxt;
      o_side_r <= dv_c_r[QW][DW-1:4];
    end
  end

  assign out_vld  = o_vld_r;
  assign out_vec  = o_vec_r;
  assign out_side = o_side_r;

endmodule

@@ rtl/look_at_view_matrix_core.sv @@
// look_at_view_matrix_core: streaming look-at view matrix, top level
// depends on lavm_pkg and lavm_norm
//
// Takes one beat of eye, target and up (signed Q.FRAC_BITS, 32 bits each) per
// clock and returns one beat with the nine rotation entries (18-bit Q1.FRAC_BITS)
// and the saturated translation column. Throughput is one beat per clock while
// out_ready is high. The datapath runs through three normalization pipelines in
// series, each with a 16-stage square root and a FRAC_BITS+1 stage restoring
// divider. A low out_ready while out_valid is high stalls the whole pipeline
// and in_ready follows it.
module look_at_view_matrix_core #(
  parameter int FRAC_BITS = 16
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [31:0] in_eye_x,
  input  logic [31:0] in_eye_y,
  input  logic [31:0] in_eye_z,
  input  logic [31:0] in_target_x,
  input  logic [31:0] in_target_y,
  input  logic [31:0] in_target_z,
  input  logic [31:0] in_upvec_x,
  input  logic [31:0] in_upvec_y,
  input  logic [31:0] in_upvec_z,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [17:0] out_side_x,
  output logic [17:0] out_side_y,
  output logic [17:0] out_side_z,
  output logic [17:0] out_newup_x,
  output logic [17:0] out_newup_y,
  output logic [17:0] out_newup_z,
  output logic [17:0] out_fwd_x,
  output logic [17:0] out_fwd_y,
  output logic [17:0] out_fwd_z,
  output logic [31:0] out_trans_x,
  output logic [31:0] out_trans_y,
  output logic [31:0] out_trans_z
);

  localparam int CWD = lavm_pkg::COORD_W;
  localparam int RW  = lavm_pkg::ROT_W;
  localparam int OW  = FRAC_BITS + 2;
  localparam int DW0 = CWD + 1;
  localparam int PW1 = CWD + OW;
  localparam int W1  = PW1 + 1;
  localparam int PW2 = 2 * OW;
  localparam int W2  = PW2 + 1;
  localparam int PT  = OW + CWD;
  localparam int TW  = PT + 2;
  localparam int EW  = 3 * CWD;
  localparam int VW  = 3 * OW;

  logic en;
  logic out_valid_r;

  assign en       = !out_valid_r || out_ready;
  assign in_ready = en;

  // input stage: difference eye minus target
  logic             s0_vld_r;
  logic [3*DW0-1:0] s0_d_r;
  logic [EW-1:0]    s0_eye_r;
  logic [EW-1:0]    s0_up_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s0_vld_r <= 1'b0;
    end else if (en) begin
      s0_vld_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s0_d_r   <= {DW0'($signed(in_eye_z)) - DW0'($signed(in_target_z)),
                   DW0'($signed(in_eye_y)) - DW0'($signed(in_target_y)),
                   DW0'($signed(in_eye_x)) - DW0'($signed(in_target_x))};
      s0_eye_r <= {in_eye_z, in_eye_y, in_eye_x};
      s0_up_r  <= {in_upvec_z, in_upvec_y, in_upvec_x};
    end
  end

  // forward
  logic                n0_vld;
  logic [VW-1:0]       n0_vec;
  logic [2*EW-1:0]     n0_side;

  lavm_norm #(.W(DW0), .FB(FRAC_BITS), .SW(2*EW)) u_norm_fwd (
    .clk      (clk),
    .rst_n    (rst_n),
    .en       (en),
    .in_vld   (s0_vld_r),
    .in_vec   (s0_d_r),
    .in_side  ({s0_eye_r, s0_up_r}),
    .out_vld  (n0_vld),
    .out_vec  (n0_vec),
    .out_side (n0_side)
  );

  // side = up cross forward
  logic signed [CWD-1:0] upv [3];
  logic signed [OW-1:0]  f0v [3];
  logic                  x1_vld_r;
  logic signed [PW1-1:0] x1_p_r [6];
  logic [EW+VW-1:0]      x1_side_r;
  logic                  x2_vld_r;
  logic [3*W1-1:0]       x2_vec_r;
  logic [EW+VW-1:0]      x2_side_r;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      upv[i] = $signed(n0_side[i*CWD +: CWD]);
      f0v[i] = $signed(n0_vec[i*OW +: OW]);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      x1_vld_r <= 1'b0;
      x2_vld_r <= 1'b0;
    end else if (en) begin
      x1_vld_r <= n0_vld;
      x2_vld_r <= x1_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      x1_p_r[0] <= upv[1] * f0v[2];
      x1_p_r[1] <= upv[2] * f0v[1];
      x1_p_r[2] <= upv[2] * f0v[0];
      x1_p_r[3] <= upv[0] * f0v[2];
      x1_p_r[4] <= upv[0] * f0v[1];
      x1_p_r[5] <= upv[1] * f0v[0];
      x1_side_r <= {n0_side[2*EW-1:EW], n0_vec};
      for (int i = 0; i < 3; i++) begin
        x2_vec_r[i*W1 +: W1] <= W1'(x1_p_r[2*i]) - W1'(x1_p_r[2*i+1]);
      end
      x2_side_r <= x1_side_r;
    end
  end

  logic             n1_vld;
  logic [VW-1:0]    n1_vec;
  logic [EW+VW-1:0] n1_side;

  lavm_norm #(.W(W1), .FB(FRAC_BITS), .SW(EW+VW)) u_norm_side (
    .clk      (clk),
    .rst_n    (rst_n),
    .en       (en),
    .in_vld   (x2_vld_r),
    .in_vec   (x2_vec_r),
    .in_side  (x2_side_r),
    .out_vld  (n1_vld),
    .out_vec  (n1_vec),
    .out_side (n1_side)
  );

  // newup = forward cross side
  logic signed [OW-1:0]  f1v [3];
  logic signed [OW-1:0]  s1v [3];
  logic                  y1_vld_r;
  logic signed [PW2-1:0] y1_p_r [6];
  logic [EW+2*VW-1:0]    y1_side_r;
  logic                  y2_vld_r;
  logic [3*W2-1:0]       y2_vec_r;
  logic [EW+2*VW-1:0]    y2_side_r;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      f1v[i] = $signed(n1_side[i*OW +: OW]);
      s1v[i] = $signed(n1_vec[i*OW +: OW]);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      y1_vld_r <= 1'b0;
      y2_vld_r <= 1'b0;
    end else if (en) begin
      y1_vld_r <= n1_vld;
      y2_vld_r <= y1_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      y1_p_r[0] <= f1v[1] * s1v[2];
      y1_p_r[1] <= f1v[2] * s1v[1];
      y1_p_r[2] <= f1v[2] * s1v[0];
      y1_p_r[3] <= f1v[0] * s1v[2];
      y1_p_r[4] <= f1v[0] * s1v[1];
      y1_p_r[5] <= f1v[1] * s1v[0];
      y1_side_r <= {n1_side, n1_vec};
      for (int i = 0; i < 3; i++) begin
        y2_vec_r[i*W2 +: W2] <= W2'(y1_p_r[2*i]) - W2'(y1_p_r[2*i+1]);
      end
      y2_side_r <= y1_side_r;
    end
  end

  logic               n2_vld;
  logic [VW-1:0]      n2_vec;
  logic [EW+2*VW-1:0] n2_side;

  lavm_norm #(.W(W2), .FB(FRAC_BITS), .SW(EW+2*VW)) u_norm_up (
    .clk      (clk),
    .rst_n    (rst_n),
    .en       (en),
    .in_vld   (y2_vld_r),
    .in_vec   (y2_vec_r),
    .in_side  (y2_side_r),
    .out_vld  (n2_vld),
    .out_vec  (n2_vec),
    .out_side (n2_side)
  );

  // translation: minus rows dot eye, rounded and saturated
  // rotation pack: row 0 side, row 1 newup, row 2 forward
  logic [3*VW-1:0]       rot;
  logic signed [CWD-1:0] eyv [3];
  logic signed [OW-1:0]  rowv [3][3];
  logic                  t1_vld_r;
  logic signed [PT-1:0]  t1_p_r [3][3];
  logic [3*VW-1:0]       t1_rot_r;
  logic                  t2_vld_r;
  logic signed [TW-1:0]  t2_dot_r [3];
  logic [3*VW-1:0]       t2_rot_r;
  logic                  t3_vld_r;
  logic [2:0]            t3_neg_r;
  logic [TW-1:0]         t3_mt_r [3];
  logic [3*VW-1:0]       t3_rot_r;
  logic [TW-1:0]         mag_nxt [3];

  assign rot = {n2_side[2*VW-1:VW], n2_vec, n2_side[VW-1:0]};

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      eyv[i] = $signed(n2_side[2*VW + i*CWD +: CWD]);
      for (int j = 0; j < 3; j++) begin
        rowv[i][j] = $signed(rot[i*VW + j*OW +: OW]);
      end
      mag_nxt[i] = t2_dot_r[i][TW-1] ? (TW'(0) - TW'(t2_dot_r[i])) : TW'(t2_dot_r[i]);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      t1_vld_r <= 1'b0;
      t2_vld_r <= 1'b0;
      t3_vld_r <= 1'b0;
    end else if (en) begin
      t1_vld_r <= n2_vld;
      t2_vld_r <= t1_vld_r;
      t3_vld_r <= t2_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        for (int j = 0; j < 3; j++) begin
          t1_p_r[i][j] <= rowv[i][j] * eyv[j];
        end
        t2_dot_r[i] <= TW'(t1_p_r[i][0]) + TW'(t1_p_r[i][1]) + TW'(t1_p_r[i][2]);
        t3_neg_r[i] <= !t2_dot_r[i][TW-1] && (t2_dot_r[i] != '0);
        t3_mt_r[i]  <= (mag_nxt[i] + (TW'(1) << (FRAC_BITS - 1))) >> FRAC_BITS;
      end
      t1_rot_r <= rot;
      t2_rot_r <= t1_rot_r;
      t3_rot_r <= t2_rot_r;
    end
  end

  // output register
  localparam logic [TW-1:0] NEG_LIM = TW'(33'h0_8000_0000);
  localparam logic [TW-1:0] POS_LIM = TW'(33'h0_7FFF_FFFF);

  logic [CWD-1:0] trans_nxt [3];
  logic [CWD-1:0] trans_r   [3];
  logic [RW-1:0]  rot_r     [9];

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      if (t3_neg_r[i]) begin
        trans_nxt[i] = CWD'(0) - ((t3_mt_r[i] > NEG_LIM) ? CWD'(NEG_LIM) : CWD'(t3_mt_r[i]));
      end else begin
        trans_nxt[i] = (t3_mt_r[i] > POS_LIM) ? CWD'(POS_LIM) : CWD'(t3_mt_r[i]);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (en) begin
      out_valid_r <= t3_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      trans_r <= trans_nxt;
      for (int k = 0; k < 9; k++) begin
        rot_r[k] <= RW'($signed(t3_rot_r[k*OW +: OW]));
      end
    end
  end

  assign out_valid   = out_valid_r;
  assign out_side_x  = rot_r[0];
  assign out_side_y  = rot_r[1];
  assign out_side_z  = rot_r[2];
  assign out_newup_x = rot_r[3];
  assign out_newup_y = rot_r[4];
  assign out_newup_z = rot_r[5];
  assign out_fwd_x   = rot_r[6];
  assign out_fwd_y   = rot_r[7];
  assign out_fwd_z   = rot_r[8];
  assign out_trans_x = trans_r[0];
  assign out_trans_y = trans_r[1];
  assign out_trans_z = trans_r[2];

  // zero forward means eye on target, so side x, newup y and trans z must be zero
  a_zero_fwd: assert property (@(posedge clk) disable iff (!rst_n)
    (FRAC_BITS <= 16 && out_valid && out_fwd_x == '0 && out_fwd_y == '0 &&
     out_fwd_z == '0) |-> (out_side_x == '0 && out_newup_y == '0 && out_trans_z == '0))
    else $error("zero forward vector with nonzero matrix entries");

  a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_ready) |=> (out_valid && $stable(out_trans_x) &&
     $stable(out_side_z) && $stable(out_fwd_y)))
    else $error("result beat changed while stalled");

  a_unit_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (FRAC_BITS <= 16 && out_valid) |->
    ($signed(out_fwd_x) <= $signed(RW'(1) << FRAC_BITS) &&
     $signed(out_fwd_x) >= -$signed(RW'(1) << FRAC_BITS)))
    else $error("rotation entry exceeds unit magnitude");

endmodule
